[rtl/core/b2d_pkg.sv]
// Shared types and constants for the binary to decimal ASCII converter.
`default_nettype none

package b2d_pkg;

    // Width of the value port, fixed by the interface.
    localparam int unsigned VALUE_PORT_W = 64;

    // Width of one ASCII digit word and the code of the character '0'.
    localparam int unsigned CHAR_W     = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Width of one BCD digit.
    localparam int unsigned BCD_W = 4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_EMIT
    } t_state;

    // Commands from the sequencer to the shift-add-3 unit.
    typedef struct packed {
        logic load;
        logic step;
    } t_dab_ctrl;

endpackage

`default_nettype wire

[rtl/core/binary_to_decimal_ascii.sv]
// Top level of the binary to decimal ASCII converter: sequencer and output stage.
//
// The input channel (i_value_valid, o_value_ready, i_value) takes one unsigned
// word; only its low VALUE_WIDTH bits are converted. The output channel
// (o_digit_valid, i_digit_ready, o_digit_char, o_last_digit) gives one word per
// decimal digit, most significant first, with leading zeros suppressed. Zero
// gives the single digit '0'. o_last_digit marks the least significant digit.
// Where the value has more digits than MAX_DIGITS, only the low MAX_DIGITS
// digits are given.
// Order of work: after acceptance the shift-add-3 unit shifts through every bit
// of the value, then the leading-zero scan walks down past suppressed digits,
// then one digit leaves per cycle while the receiver takes them. A new value is
// only accepted once the last digit of the value before it has been loaded into
// the output register, since the loop over the binary bits runs through the
// single adjust-and-shift unit. o_value_ready is high only in the idle state.
// A stalled receiver holds the output register and the sequencer waits in the
// emit state; nothing is lost. Reset clears the sequencer to idle and drops
// o_digit_valid; a word held in the output register at reset is discarded.
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_DIGITS  = 20
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_value_valid,
    output logic                                    o_value_ready,
    input  wire logic [b2d_pkg::VALUE_PORT_W-1:0]   i_value,
    output logic                                    o_digit_valid,
    input  wire logic                               i_digit_ready,
    output logic      [b2d_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                                    o_last_digit
);

    localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(MAX_DIGITS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    b2d_pkg::t_state    r_state;
    b2d_pkg::t_state    n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [b2d_pkg::CHAR_W-1:0] r_out_char;
    logic [b2d_pkg::CHAR_W-1:0] n_out_char;
    logic               r_out_last;
    logic               n_out_last;
    logic               w_out_load;

    b2d_pkg::t_dab_ctrl         w_ctrl;
    logic [b2d_pkg::BCD_W-1:0]  w_digit;
    logic                       w_ovf;

    // The shared adjust-and-shift unit that holds the number while it is
    // turned into BCD, and reads back one digit chosen by the sequencer.
    b2d_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dabble (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_value  (i_value),
        .i_rd_idx (r_idx),
        .o_digit  (w_digit),
        .o_ovf    (w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b2d_pkg::S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload needs no reset: it is only looked at with o_digit_valid.
    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        w_ctrl        = '0;
        o_value_ready = 1'b0;
        w_out_load    = 1'b0;

        unique case (r_state)
            b2d_pkg::S_IDLE: begin
                o_value_ready = 1'b1;
                if (i_value_valid) begin
                    w_ctrl.load = 1'b1;
                    n_cnt       = '0;
                    n_state     = b2d_pkg::S_CONV;
                end
            end
            b2d_pkg::S_CONV: begin
                w_ctrl.step = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_idx   = IDX_TOP;
                    n_state = b2d_pkg::S_SCAN;
                end
            end
            b2d_pkg::S_SCAN: begin
                // Walk down past leading zero digits; the lowest digit always
                // goes out, so zero still gives one word. When the value had
                // more digits than are held, every held digit goes out, zeros
                // at the top included.
                if (w_digit == '0 && r_idx != '0 && !w_ovf) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_state = b2d_pkg::S_EMIT;
                end
            end
            b2d_pkg::S_EMIT: begin
                if (!r_out_valid || i_digit_ready) begin
                    w_out_load = 1'b1;
                    if (r_idx == '0) begin
                        n_state = b2d_pkg::S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = b2d_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: a taken word clears valid, a new word sets it again.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (i_digit_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
            n_out_char  = b2d_pkg::ASCII_ZERO + {2'b00, w_digit};
            n_out_last  = (r_idx == '0);
        end
    end

    assign o_digit_valid = r_out_valid;
    assign o_digit_char  = r_out_char;
    assign o_last_digit  = r_out_last;

    // A delivered word is always a decimal digit character.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |-> (o_digit_char >= 6'd48 && o_digit_char <= 6'd57))
        else $error("digit word outside '0' to '9'");

    // The final conversion step hands over to the scan at the top digit.
    a_conv_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2d_pkg::S_CONV && r_cnt == CNT_LAST)
        |=> (r_state == b2d_pkg::S_SCAN && r_idx == IDX_TOP))
        else $error("conversion did not end in the scan at the top digit");

    // The word flagged as last is loaded only when the sequencer goes idle.
    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_idx == '0) |=> (r_state == b2d_pkg::S_IDLE && o_last_digit))
        else $error("last digit did not end the run");

endmodule

`default_nettype wire

[rtl/core/b2d_dabble.sv]
// Shift-add-3 unit: binary shift register, BCD register and digit read-out.
`default_nettype none

module b2d_dabble #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_DIGITS  = 20
) (
    input  wire logic                                   i_clk,
    input  wire b2d_pkg::t_dab_ctrl                     i_ctrl,
    input  wire logic [b2d_pkg::VALUE_PORT_W-1:0]       i_value,
    input  wire logic [$clog2(MAX_DIGITS)-1:0]          i_rd_idx,
    output logic      [b2d_pkg::BCD_W-1:0]              o_digit,
    output logic                                        o_ovf
);

    localparam int unsigned BCD_TOTAL = MAX_DIGITS * b2d_pkg::BCD_W;

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [VALUE_WIDTH-1:0] n_bin;
    logic [BCD_TOTAL-1:0]   r_bcd;
    logic [BCD_TOTAL-1:0]   n_bcd;
    logic [BCD_TOTAL-1:0]   w_adj;
    logic                   r_ovf;
    logic                   n_ovf;

    // Every digit of five or more gets three added before the shift, so that
    // doubling it carries correctly into the next digit. Carries only move
    // upwards, so dropping the digits above the top one leaves the rest exact.
    always_comb begin
        for (int i = 0; i < int'(MAX_DIGITS); i++) begin
            if (r_bcd[i*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] >= 4'd5) begin
                w_adj[i*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] =
                    r_bcd[i*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] + 4'd3;
            end else begin
                w_adj[i*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] =
                    r_bcd[i*b2d_pkg::BCD_W +: b2d_pkg::BCD_W];
            end
        end
    end

    // A carry that falls off the top digit means the value has more digits
    // than are held; it is kept until the next load.
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_ovf = r_ovf;
        if (i_ctrl.load) begin
            n_bin = i_value[VALUE_WIDTH-1:0];
            n_bcd = '0;
            n_ovf = 1'b0;
        end else if (i_ctrl.step) begin
            n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
            n_bcd = {w_adj[BCD_TOTAL-2:0], r_bin[VALUE_WIDTH-1]};
            n_ovf = r_ovf | w_adj[BCD_TOTAL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_ovf <= n_ovf;
    end

    assign o_digit = r_bcd[int'(i_rd_idx)*b2d_pkg::BCD_W +: b2d_pkg::BCD_W];
    assign o_ovf   = r_ovf;

endmodule

`default_nettype wire
